### hw/rtl/audio_highpass_compressor_assert.svh
// Assertion macros shared by the audio high-pass compressor RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef AUDIO_HIGHPASS_COMPRESSOR_ASSERT_SVH
`define AUDIO_HIGHPASS_COMPRESSOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only out of reset
`define ACOMP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ACOMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACOMP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ACOMP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/acomp_pkg.sv
// Shared types, constants and constant tables for the high-pass compressor.
// No dependencies.
package acomp_pkg;
	localparam int SampleW = 16;
	localparam int EnvW    = 24;
	localparam int CoefW   = 16;
	localparam int MulW    = 33;

	localparam logic [63:0] B1_ABS = (64'd17786317778 * 64'd268435456 + 64'd1250000000)
		/ 64'd2500000000;
	localparam logic [63:0] B2_ABS = (64'd8008026467 * 64'd268435456 + 64'd1250000000)
		/ 64'd2500000000;
	localparam logic signed [31:0] HP_B1 = B1_ABS[31:0];
	localparam logic signed [31:0] HP_B2 = -B2_ABS[31:0];

	localparam logic [EnvW-1:0] ENV_MAX = '1;
	localparam logic [20:0]     LOG_ONE = 21'(EnvW) << 16;

	localparam logic [1:0] REG_ATTACK  = 2'd0;
	localparam logic [1:0] REG_RELEASE = 2'd1;
	localparam logic [1:0] REG_FLOOR   = 2'd2;

	typedef struct packed {
		logic [CoefW-1:0] attack;
		logic [CoefW-1:0] release_c;
		logic [EnvW-1:0]  env_floor;
	} cfg_t;

	typedef struct packed {
		logic                      clipped;
		logic signed [SampleW-1:0] audio_out;
	} res_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] b;
		res = '0;
		rem = v;
		for (int i = 31; i >= 0; i--) begin
			b = 64'd1 << (2 * i);
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// 2^(2^-k) in Q1.30, each the truncated square root of the one before
	function automatic logic [30:0] exp_root(int k);
		logic [63:0] r;
		r = 64'd2 << 30;
		for (int i = 0; i < 16; i++) begin
			if (i < k) r = isqrt64(r << 30);
		end
		return r[30:0];
	endfunction

	localparam logic [30:0] EXP_ROOT [16] = '{
		exp_root(1), exp_root(2), exp_root(3), exp_root(4),
		exp_root(5), exp_root(6), exp_root(7), exp_root(8),
		exp_root(9), exp_root(10), exp_root(11), exp_root(12),
		exp_root(13), exp_root(14), exp_root(15), exp_root(16)
	};
endpackage

### hw/rtl/acomp_mul.sv
// Shared signed multiplier used by the filter, envelope, log2, exp2 and output scale steps of the sequencer.
// Depends on acomp_pkg.
module acomp_mul import acomp_pkg::*; (
	input  logic signed [MulW-1:0]   a,
	input  logic signed [MulW-1:0]   b,
	output logic signed [2*MulW-1:0] p
);
	assign p = a * b;
endmodule

### hw/rtl/acomp_core.sv
// Sequencer and datapath: biquad, envelope follower, log2/exp2 gain, output scale.
// Depends on acomp_pkg, acomp_mul and the assertion macro header.
`include "audio_highpass_compressor_assert.svh"
module acomp_core import acomp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [SampleW-1:0] sample,
	input  logic                      load_envelope,
	input  logic [EnvW-1:0]           envelope_preset,
	input  cfg_t                      cfg,
	output logic                      idle,
	output logic                      res_valid,
	input  logic                      res_ready,
	output res_t                      res
);
	typedef enum logic [3:0] {
		S_IDLE, S_FIR_A, S_FIR_B, S_ENV, S_NORM, S_LOG, S_GAIN, S_EXP, S_FIN, S_OUT, S_DONE
	} state_t;

	localparam logic signed [65:0] Y_MAX = 66'sd2147483647;
	localparam logic signed [65:0] Y_MIN = -66'sd2147483648;
	localparam logic signed [65:0] RND   = 66'sd1 <<< 29;

	state_t                    state_q;
	logic signed [SampleW-1:0] x_q, h0_q, h1_q;
	logic signed [31:0]        y0_q, y1_q;
	logic signed [65:0]        acc_q;
	logic [31:0]               mag_q;
	logic                      neg_q;
	logic [EnvW-1:0]           env_q;
	logic [30:0]               lm_q;
	logic [4:0]                p_q;
	logic [15:0]               frac_q;
	logic [3:0]                cnt_q;
	logic [4:0]                gi_q;
	logic [15:0]               gf_q;
	logic [30:0]               ex_q;
	logic [62:0]               prod_q;
	res_t                      res_q;

	logic signed [MulW-1:0]   ma, mb;
	logic signed [2*MulW-1:0] prod;

	acomp_mul u_mul (.a(ma), .b(mb), .p(prod));

	// datapath helpers
	logic signed [17:0] xs;
	logic signed [65:0] xsh, ysum, yw;
	logic signed [31:0] ysat;
	logic [EnvW-1:0]    lv, e, emax;
	logic               up;
	logic signed [24:0] diff;
	logic signed [25:0] newv;
	logic [4:0]         msb;
	logic [31:0]        tsq;
	logic [20:0]        dl;
	logic [22:0]        g3;
	logic [5:0]         sh;
	logic [62:0]        mm;

	always_comb begin
		xs   = 18'(x_q) + 18'(h1_q) - (18'(h0_q) <<< 1);
		xsh  = 66'(xs) <<< 39;
		ysum = acc_q + prod + RND;
		yw   = ysum >>> 30;
		if (yw > Y_MAX)      ysat = 32'h7fff_ffff;
		else if (yw < Y_MIN) ysat = 32'h8000_0000;
		else                 ysat = yw[31:0];
		lv   = (mag_q > 32'(ENV_MAX)) ? ENV_MAX : mag_q[EnvW-1:0];
		up   = lv > env_q;
		diff = $signed({1'b0, lv}) - $signed({1'b0, env_q});
		newv = $signed({2'b0, env_q}) + 26'(prod >>> 16);
		emax = (env_q > cfg.env_floor) ? env_q : cfg.env_floor;
		e    = (emax == '0) ? EnvW'(1) : emax;
		msb  = '0;
		for (int i = 0; i < EnvW; i++) begin
			if (e[i]) msb = 5'(i);
		end
		tsq  = prod[61:30];
		dl   = LOG_ONE - {p_q, frac_q};
		g3   = {2'b0, dl} + {1'b0, dl, 1'b0};
		sh   = 6'd39 - {1'b0, gi_q};
		mm   = prod_q >> sh;
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_FIR_A: begin
				ma = MulW'(HP_B1);
				mb = MulW'(y0_q);
			end
			S_FIR_B: begin
				ma = MulW'(HP_B2);
				mb = MulW'(y1_q);
			end
			S_ENV: begin
				ma = $signed({17'b0, up ? cfg.attack : cfg.release_c});
				mb = MulW'(diff);
			end
			S_LOG: begin
				ma = $signed({2'b0, lm_q});
				mb = $signed({2'b0, lm_q});
			end
			S_EXP: begin
				ma = $signed({2'b0, ex_q});
				mb = $signed({2'b0, EXP_ROOT[cnt_q]});
			end
			S_FIN: begin
				ma = $signed({1'b0, mag_q});
				mb = $signed({2'b0, ex_q});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			h0_q    <= '0;
			h1_q    <= '0;
			y0_q    <= '0;
			y1_q    <= '0;
			env_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (load_envelope) env_q <= envelope_preset;
						x_q <= sample;
						if (sample == '0) begin
							res_q   <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_FIR_A;
						end
					end
				end
				S_FIR_A: begin
					acc_q   <= xsh + prod;
					state_q <= S_FIR_B;
				end
				S_FIR_B: begin
					h1_q    <= h0_q;
					h0_q    <= x_q;
					y1_q    <= y0_q;
					y0_q    <= ysat;
					neg_q   <= ysat[31];
					mag_q   <= ysat[31] ? (~ysat + 32'd1) : ysat;
					state_q <= S_ENV;
				end
				S_ENV: begin
					env_q   <= newv[24] ? ENV_MAX : newv[EnvW-1:0];
					state_q <= S_NORM;
				end
				S_NORM: begin
					p_q     <= msb;
					lm_q    <= {7'b0, e} << (5'd30 - msb);
					frac_q  <= '0;
					cnt_q   <= '0;
					state_q <= S_LOG;
				end
				S_LOG: begin
					if (tsq[31]) begin
						lm_q   <= tsq[31:1];
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						lm_q   <= tsq[30:0];
						frac_q <= {frac_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= S_GAIN;
				end
				S_GAIN: begin
					gi_q    <= g3[22:18];
					gf_q    <= g3[17:2];
					ex_q    <= 31'h4000_0000;
					cnt_q   <= '0;
					state_q <= S_EXP;
				end
				S_EXP: begin
					if (gf_q[~cnt_q]) ex_q <= prod[60:30];
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= S_FIN;
				end
				S_FIN: begin
					prod_q  <= prod[62:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!neg_q) begin
						res_q.clipped   <= mm > 63'd32767;
						res_q.audio_out <= (mm > 63'd32767) ? 16'sh7fff : mm[15:0];
					end else begin
						res_q.clipped   <= mm > 63'd32768;
						res_q.audio_out <= (mm > 63'd32768) ? 16'sh8000 : (~mm[15:0] + 16'd1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle      = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = res_q;

	`ACOMP_ASSERT(a_start_idle, clk, arst_n, start |-> state_q == S_IDLE, "start while busy")
	`ACOMP_ASSERT(a_log_norm, clk, arst_n, state_q == S_LOG |-> lm_q[30], "log mantissa not normalized")
	`ACOMP_ASSERT(a_gain_range, clk, arst_n, state_q == S_EXP |-> gi_q <= 5'd18, "gain exponent out of range")
	`ACOMP_ASSERT(a_done_leave, clk, arst_n, (res_valid && res_ready) |=> state_q == S_IDLE, "result not released")
	`ACOMP_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> state_q == S_IDLE, "not idle in reset")
endmodule

### hw/rtl/audio_highpass_compressor.sv
// Top level: stream ports, configuration registers and output word register.
// Depends on acomp_pkg and acomp_core.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tdata: sample, envelope_preset; tuser: load_envelope
//  m_axis    out  m_axis_tvalid/tready   tdata: audio_out; tuser: clipped
//  cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// m_axis_tvalid rises once a nonzero sample has passed the filter, envelope, normalize, 16
// log2 squarings, gain, 16 exp2 steps and output scale, its multiplies taking turns on the
// shared multiplier; a zero sample goes straight to the result. One word is in the
// sequencer; s_axis_tready is high only while the sequencer is idle. The output register
// lets the next word in while a result waits. Reset clears filter history, envelope and
// registers to their defaults. cfg_ready is always high.
module audio_highpass_compressor import acomp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [15:0] sample, [39:16] envelope_preset
	input  logic        s_axis_tuser,   // [0] load_envelope
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] audio_out
	output logic        m_axis_tuser,   // [0] clipped
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	cfg_t cfg_q;
	res_t core_res, out_q;
	logic out_valid_q;
	logic core_idle, core_valid, core_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack    <= 16'd8192;
			cfg_q.release_c <= 16'd16;
			cfg_q.env_floor <= 24'd16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ATTACK:  cfg_q.attack    <= cfg_data[15:0];
				REG_RELEASE: cfg_q.release_c <= cfg_data[15:0];
				REG_FLOOR:   cfg_q.env_floor <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = core_idle;
	assign core_take     = core_valid && (!out_valid_q || m_axis_tready);

	acomp_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (s_axis_tvalid && core_idle),
		.sample          ($signed(s_axis_tdata[15:0])),
		.load_envelope   (s_axis_tuser),
		.envelope_preset (s_axis_tdata[39:16]),
		.cfg             (cfg_q),
		.idle            (core_idle),
		.res_valid       (core_valid),
		.res_ready       (core_take),
		.res             (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (core_take) begin
				out_valid_q <= 1'b1;
				out_q       <= core_res;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.audio_out;
	assign m_axis_tuser  = out_q.clipped;
endmodule
